// File: design/asgr_pkg.sv
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types, character codes and helper functions for the SGR colour
// parser: parse modes, the result and input records, colour application and digit accumulation.
// ----------------------------------------------------------------------------
package asgr_pkg;

  // Byte and colour widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOUR_W = 3;
  localparam int unsigned PARAM_W  = 7;
  localparam int unsigned DCNT_W   = 2;

  // Control characters
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h6D;  // 'm'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  // SGR foreground range and default colour
  localparam logic [PARAM_W-1:0]  SGR_FG_LOW   = 7'd30;
  localparam logic [PARAM_W-1:0]  SGR_FG_HIGH  = 7'd37;
  localparam logic [PARAM_W-1:0]  SGR_BOLD     = 7'd1;
  localparam logic [PARAM_W-1:0]  SGR_DIM      = 7'd2;
  localparam logic [PARAM_W-1:0]  SGR_ULINE    = 7'd4;
  localparam logic [PARAM_W-1:0]  SGR_BLINK    = 7'd5;
  localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 3'd7;
  localparam logic [DCNT_W-1:0]   MAX_DIGITS   = 2'd2;

  // Parser mode; code 3 is unused and handled as text mode
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  // Drawable byte produced by the parser for the current input byte
  typedef struct packed {
    logic                has;
    logic [BYTE_W-1:0]   chr;
    logic [COLOUR_W-1:0] colour;
  } result_t;

  // Input register contents
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } in_slot_t;

  // Apply one SGR value to a colour
  function automatic logic [COLOUR_W-1:0] apply_colour(
    input logic [COLOUR_W-1:0] cur,
    input logic [PARAM_W-1:0]  val
  );
    logic [PARAM_W-1:0] diff;
    diff = val - SGR_FG_LOW;
    if (val >= SGR_FG_LOW && val <= SGR_FG_HIGH) begin
      return diff[COLOUR_W-1:0];
    end else if (val == SGR_BOLD || val == SGR_DIM || val == SGR_ULINE ||
                 val == SGR_BLINK) begin
      return cur;
    end else begin
      return COLOUR_WHITE;
    end
  endfunction

  // p * 10 + d, wrapped to the parameter width
  function automatic logic [PARAM_W-1:0] digit_acc(
    input logic [PARAM_W-1:0] p,
    input logic [BYTE_W-1:0]  b
  );
    logic [BYTE_W-1:0]  d;
    logic [PARAM_W+2:0] sum;
    d   = b - CH_ZERO;
    sum = {p, 3'b000} + {2'b00, p, 1'b0} + {3'b000, d[PARAM_W-1:0]};
    return sum[PARAM_W-1:0];
  endfunction

endpackage

// File: design/asgr_in_stage.sv
// ----------------------------------------------------------------------------
// asgr_in_stage
// Input register: captures one byte per transfer and holds it until the
// parser consumes it. Stalls the sender only while a held byte cannot move.
// ----------------------------------------------------------------------------
module asgr_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [asgr_pkg::BYTE_W-1:0] in_byte,
  input  logic                        advance,
  output asgr_pkg::in_slot_t          slot
);
  import asgr_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              load;

  // Handshake
  assign in_stall = valid_r & ~advance;
  assign load     = in_valid & ~in_stall;

  // Next slot contents
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = in_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.data  = data_r;

endmodule

// File: design/asgr_parser.sv
// ----------------------------------------------------------------------------
// asgr_parser
// Escape sequence state machine. Holds mode, colour and parameter state,
// updates it for the byte in the input register and reports whether that
// byte is drawn.
// ----------------------------------------------------------------------------
module asgr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [asgr_pkg::BYTE_W-1:0] step_byte,
  output asgr_pkg::result_t           step_res
);
  import asgr_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic [PARAM_W-1:0]  first_r, first_nxt;
  logic [PARAM_W-1:0]  second_r, second_nxt;
  logic                second_seen_r, second_seen_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                stopped_r, stopped_nxt;

  logic                is_digit;
  logic                take_digit;
  logic                second_used;
  logic [COLOUR_W-1:0] colour_first;
  logic [COLOUR_W-1:0] colour_final;

  // Byte class and colour applied on 'm'
  assign is_digit     = step_byte inside {[CH_ZERO:CH_NINE]};
  assign take_digit   = is_digit & ~stopped_r & (dcnt_r < MAX_DIGITS);
  assign second_used  = second_seen_r & ((dcnt_r != '0) | stopped_r);
  assign colour_first = apply_colour(colour_r, first_r);
  assign colour_final = second_used ? apply_colour(colour_first, second_r)
                                    : colour_first;

  // Next state
  always_comb begin
    mode_nxt        = mode_r;
    colour_nxt      = colour_r;
    first_nxt       = first_r;
    second_nxt      = second_r;
    second_seen_nxt = second_seen_r;
    dcnt_nxt        = dcnt_r;
    stopped_nxt     = stopped_r;
    if (step_en) begin
      case (mode_r)
        MODE_SEQ: begin
          if (step_byte == CH_END) begin
            colour_nxt      = colour_final;
            mode_nxt        = MODE_TEXT;
            first_nxt       = '0;
            second_nxt      = '0;
            second_seen_nxt = 1'b0;
            dcnt_nxt        = '0;
            stopped_nxt     = 1'b0;
          end else if (step_byte == CH_SEMI) begin
            second_seen_nxt = 1'b1;
            second_nxt      = '0;
            dcnt_nxt        = '0;
            stopped_nxt     = 1'b0;
          end else if (is_digit) begin
            if (take_digit) begin
              if (second_seen_r) begin
                second_nxt = digit_acc(second_r, step_byte);
              end else begin
                first_nxt = digit_acc(first_r, step_byte);
              end
              dcnt_nxt = dcnt_r + 2'd1;
            end
          end else begin
            stopped_nxt = 1'b1;
          end
        end
        MODE_ESC: begin
          if (step_byte == CH_OPEN) begin
            mode_nxt        = MODE_SEQ;
            first_nxt       = '0;
            second_nxt      = '0;
            second_seen_nxt = 1'b0;
            dcnt_nxt        = '0;
            stopped_nxt     = 1'b0;
          end else begin
            mode_nxt = (step_byte == CH_ESC) ? MODE_ESC : MODE_TEXT;
          end
        end
        default: begin
          mode_nxt = (step_byte == CH_ESC) ? MODE_ESC : MODE_TEXT;
        end
      endcase
    end
  end

  // Outputs: drawable byte with the colour in force before it
  always_comb begin
    step_res.chr    = step_byte;
    step_res.colour = colour_r;
    case (mode_r)
      MODE_SEQ: step_res.has = 1'b0;
      MODE_ESC: step_res.has = (step_byte != CH_OPEN) && (step_byte != CH_ESC);
      default:  step_res.has = (step_byte != CH_ESC);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_TEXT;
      colour_r      <= COLOUR_WHITE;
      first_r       <= '0;
      second_r      <= '0;
      second_seen_r <= 1'b0;
      dcnt_r        <= '0;
      stopped_r     <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      colour_r      <= colour_nxt;
      first_r       <= first_nxt;
      second_r      <= second_nxt;
      second_seen_r <= second_seen_nxt;
      dcnt_r        <= dcnt_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

// File: design/asgr_out_stage.sv
// ----------------------------------------------------------------------------
// asgr_out_stage
// Result register: holds one drawable byte and its colour until the
// receiver takes it, and reports when it can take a new one.
// ----------------------------------------------------------------------------
module asgr_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  asgr_pkg::result_t             res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [asgr_pkg::BYTE_W-1:0]   out_char,
  output logic [asgr_pkg::COLOUR_W-1:0] out_colour
);
  import asgr_pkg::*;

  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   char_r, char_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;

  // Free when empty or being drained this cycle
  assign free = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt  = valid_r;
    char_nxt   = char_r;
    colour_nxt = colour_r;
    if (load) begin
      valid_nxt  = 1'b1;
      char_nxt   = res.chr;
      colour_nxt = res.colour;
    end else if (free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    char_r   <= char_nxt;
    colour_r <= colour_nxt;
  end

  assign out_valid  = valid_r;
  assign out_char   = char_r;
  assign out_colour = colour_r;

endmodule

// File: design/ansi_sgr_colour_parser_unit.sv
// ----------------------------------------------------------------------------
// ansi_sgr_colour_parser_unit
// SGR colour parser for a text display. Text bytes come in on the in_
// channel (in_valid / in_stall / in_byte); drawable bytes leave on the out_
// channel with their 3-bit colour index (out_char, out_colour). ESC '['
// sequences closed by 'm' change the colour and draw nothing; ESC itself
// and every byte inside a sequence produce no output transfer.
//
// Flow: a drawable byte is captured in the input register, then moved into
// the result register, where it is offered on out_ and transfers out when
// the output is not stalled. Throughput: one byte per cycle while the
// output is not stalled, set by the parser update between the two registers.
//
// Reset (rst_n low, synchronous) returns to text mode with colour white
// and empties both registers. While out_stall holds a result, the next
// byte still moves through if it draws nothing; a drawable byte waits in
// the input register and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module ansi_sgr_colour_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [asgr_pkg::BYTE_W-1:0]   in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [asgr_pkg::BYTE_W-1:0]   out_char,
  output logic [asgr_pkg::COLOUR_W-1:0] out_colour
);
  import asgr_pkg::*;

  in_slot_t slot;
  result_t  res;
  logic     out_free;
  logic     advance;
  logic     out_load;

  // Held byte moves on unless it must draw into a full, stalled output
  assign advance  = slot.valid & (~res.has | out_free);
  assign out_load = advance & res.has;

  asgr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .advance  (advance),
    .slot     (slot)
  );

  asgr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_byte (slot.data),
    .step_res  (res)
  );

  asgr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .res        (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_colour (out_colour)
  );

endmodule

// File: design/asgr_checker.sv
// ----------------------------------------------------------------------------
// asgr_checker
// Port-level checks for the SGR colour parser, bound to the top level.
// ----------------------------------------------------------------------------
module asgr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [asgr_pkg::BYTE_W-1:0]   in_byte,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [asgr_pkg::BYTE_W-1:0]   out_char,
  input logic [asgr_pkg::COLOUR_W-1:0] out_colour
);
  import asgr_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Input back-pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // ESC is never drawn
  a_no_esc_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char != CH_ESC))
    else $error("ESC byte transferred on output");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_char) && $stable(out_colour)))
    else $error("stalled result changed");

  // Sender byte is observed for completeness of the port view
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !$isunknown(in_byte))
    else $error("unknown byte transferred on input");

endmodule

bind ansi_sgr_colour_parser_unit asgr_checker u_asgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_char   (out_char),
  .out_colour (out_colour)
);
